/* hw/rtl/complex_fixed_point_alu_core_assert.svh */
// Assertion macros shared by the checker of the complex fixed-point ALU core.
// Depends on nothing; the including file supplies clock, reset and signals.
`ifndef COMPLEX_FIXED_POINT_ALU_CORE_ASSERT_SVH
`define COMPLEX_FIXED_POINT_ALU_CORE_ASSERT_SVH

// Same-cycle implication, off during reset
`define CFPA_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("cfpa: same-cycle check failed");

// Next-cycle implication, off during reset
`define CFPA_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("cfpa: next-cycle check failed");

// Next-cycle implication that also holds across reset
`define CFPA_ASSERT_ALW(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("cfpa: reset check failed");

`endif

/* hw/rtl/cfpa_pkg.sv */
// Types and constants of the complex fixed-point ALU core.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package cfpa_pkg;

    // Field width and width of the wide pre-saturation result
    localparam int DW = 32;
    localparam int RW = 68;

    // Operation codes
    localparam logic [2:0] MODE_ADD = 3'd0;
    localparam logic [2:0] MODE_SUB = 3'd1;
    localparam logic [2:0] MODE_MUL = 3'd2;
    localparam logic [2:0] MODE_DIV = 3'd3;
    localparam logic [2:0] MODE_QUO = 3'd4;
    localparam logic [2:0] MODE_REM = 3'd5;

    // Status codes
    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_OVF = 2'd1;
    localparam logic [1:0] ST_DZ  = 2'd2;

    typedef struct packed {
        logic [2:0]          mode;
        logic signed [31:0]  a_re;
        logic signed [31:0]  a_im;
        logic signed [31:0]  b_re;
        logic signed [31:0]  b_im;
    } t_in;

    typedef struct packed {
        logic signed [31:0]  res_re;
        logic signed [31:0]  res_im;
        logic [1:0]          status;
    } t_out;

    // Operands and early results that travel beside the divider
    typedef struct packed {
        logic [2:0]          mode;
        logic signed [31:0]  a_re;
        logic signed [31:0]  a_im;
        logic signed [31:0]  b_re;
        logic signed [31:0]  b_im;
        logic signed [65:0]  drt_re;
        logic signed [65:0]  drt_im;
        logic                nr_neg;
        logic                ni_neg;
        logic                dz;
    } t_side;

endpackage

/* hw/rtl/cfpa_front.sv */
// Front pipeline: operand capture, products, sums, magnitudes (four stages).
// Depends on cfpa_pkg.
`timescale 1ns / 1ps

module cfpa_front import cfpa_pkg::*; #(
    parameter int EFF_W     = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_valid,
    input  t_in         i_data,
    output logic        o_valid,
    output t_side       o_side,
    output logic [63:0] o_num_re,
    output logic [63:0] o_num_im,
    output logic [63:0] o_den
);

    localparam int SH = DW - EFF_W;
    localparam logic signed [65:0] RND = (66'sd1 <<< FRAC_BITS) - 66'sd1;

    function automatic logic signed [31:0] take(input logic [31:0] x);
        logic signed [31:0] t;
        t = $signed(x) <<< SH;
        return t >>> SH;
    endfunction

    function automatic logic signed [65:0] tz_shift(input logic signed [65:0] x);
        logic signed [65:0] b;
        b = x[65] ? RND : 66'sd0;
        return (x + b) >>> FRAC_BITS;
    endfunction

    function automatic logic [63:0] mag64(input logic signed [65:0] x);
        logic signed [65:0] m;
        m = x[65] ? -x : x;
        return m[63:0];
    endfunction

    // Stage 0: capture operands, keep the low EFF_W bits sign-extended
    logic               r0_v;
    logic [2:0]         r0_mode;
    logic signed [31:0] r0_ar, r0_ai, r0_br, r0_bi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v <= 1'b0;
        end else if (i_en) begin
            r0_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r0_mode <= i_data.mode;
            r0_ar   <= take(i_data.a_re);
            r0_ai   <= take(i_data.a_im);
            r0_br   <= take(i_data.b_re);
            r0_bi   <= take(i_data.b_im);
        end
    end

    // Stage 1: six products, add or subtract
    logic               r1_v;
    logic [2:0]         r1_mode;
    logic signed [31:0] r1_ar, r1_ai, r1_br, r1_bi;
    logic signed [63:0] r1_p_rr, r1_p_ii, r1_p_ri, r1_p_ir, r1_p_bre, r1_p_bim;
    logic signed [32:0] r1_sum_re, r1_sum_im;
    logic               r1_dz;
    logic signed [32:0] w_ar, w_ai, w_br, w_bi;

    assign w_ar = 33'(r0_ar);
    assign w_ai = 33'(r0_ai);
    assign w_br = 33'(r0_br);
    assign w_bi = 33'(r0_bi);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (i_en) begin
            r1_v <= r0_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_mode   <= r0_mode;
            r1_ar     <= r0_ar;
            r1_ai     <= r0_ai;
            r1_br     <= r0_br;
            r1_bi     <= r0_bi;
            r1_p_rr   <= r0_ar * r0_br;
            r1_p_ii   <= r0_ai * r0_bi;
            r1_p_ri   <= r0_ar * r0_bi;
            r1_p_ir   <= r0_ai * r0_br;
            r1_p_bre  <= r0_br * r0_br;
            r1_p_bim  <= r0_bi * r0_bi;
            r1_sum_re <= (r0_mode == MODE_SUB) ? w_ar - w_br : w_ar + w_br;
            r1_sum_im <= (r0_mode == MODE_SUB) ? w_ai - w_bi : w_ai + w_bi;
            r1_dz     <= (r0_br == 32'sd0) && (r0_bi == 32'sd0);
        end
    end

    // Stage 2: product sums for multiply and divide, divisor norm
    logic               r2_v;
    logic [2:0]         r2_mode;
    logic signed [31:0] r2_ar, r2_ai, r2_br, r2_bi;
    logic signed [65:0] r2_mr, r2_mi, r2_nr, r2_ni;
    logic [63:0]        r2_den;
    logic signed [32:0] r2_sum_re, r2_sum_im;
    logic               r2_dz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (i_en) begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_mode   <= r1_mode;
            r2_ar     <= r1_ar;
            r2_ai     <= r1_ai;
            r2_br     <= r1_br;
            r2_bi     <= r1_bi;
            r2_mr     <= 66'(r1_p_rr) - 66'(r1_p_ii);
            r2_mi     <= 66'(r1_p_ri) + 66'(r1_p_ir);
            r2_nr     <= 66'(r1_p_rr) + 66'(r1_p_ii);
            r2_ni     <= 66'(r1_p_ir) - 66'(r1_p_ri);
            r2_den    <= r1_p_bre[63:0] + r1_p_bim[63:0];
            r2_sum_re <= r1_sum_re;
            r2_sum_im <= r1_sum_im;
            r2_dz     <= r1_dz;
        end
    end

    // Stage 3: round the product toward zero, split numerators into sign and magnitude
    logic signed [65:0] w_drt_re, w_drt_im;

    always_comb begin
        case (r2_mode)
            MODE_ADD, MODE_SUB: begin
                w_drt_re = 66'(r2_sum_re);
                w_drt_im = 66'(r2_sum_im);
            end
            MODE_MUL: begin
                w_drt_re = tz_shift(r2_mr);
                w_drt_im = tz_shift(r2_mi);
            end
            default: begin
                w_drt_re = 66'sd0;
                w_drt_im = 66'sd0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_side.mode   <= r2_mode;
            o_side.a_re   <= r2_ar;
            o_side.a_im   <= r2_ai;
            o_side.b_re   <= r2_br;
            o_side.b_im   <= r2_bi;
            o_side.drt_re <= w_drt_re;
            o_side.drt_im <= w_drt_im;
            o_side.nr_neg <= r2_nr[65];
            o_side.ni_neg <= r2_ni[65];
            o_side.dz     <= r2_dz;
            o_num_re      <= mag64(r2_nr);
            o_num_im      <= mag64(r2_ni);
            o_den         <= r2_den;
        end
    end

endmodule

/* hw/rtl/cfpa_div.sv */
// Pipelined restoring divider, one quotient bit per stage, two lanes sharing a divisor.
// Depends on cfpa_pkg; carries the side record alongside the quotient.
`timescale 1ns / 1ps

module cfpa_div import cfpa_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_valid,
    input  t_side                      i_side,
    input  logic [63:0]                i_num_re,
    input  logic [63:0]                i_num_im,
    input  logic [63:0]                i_den,
    output logic                       o_valid,
    output t_side                      o_side,
    output logic [FRAC_BITS+32:0]      o_q_re,
    output logic [FRAC_BITS+32:0]      o_q_im
);

    // Quotient magnitude stays below 2^(FRAC_BITS+32), so QB bits suffice
    localparam int QB = FRAC_BITS + 33;

    logic          r_v    [QB];
    t_side         r_side [QB];
    logic [63:0]   r_den  [QB];
    logic [62:0]   r_rem_re [QB];
    logic [62:0]   r_rem_im [QB];
    logic [QB-1:0] r_sh_re  [QB];
    logic [QB-1:0] r_sh_im  [QB];

    genvar k;
    generate
        for (k = 0; k < QB; k++) begin : g_stage
            logic          w_v;
            t_side         w_side;
            logic [63:0]   w_den;
            logic [62:0]   w_rem_re, w_rem_im;
            logic [QB-1:0] w_sh_re, w_sh_im;
            logic [63:0]   w_t_re, w_t_im;
            logic          w_ge_re, w_ge_im;
            logic [63:0]   w_d_re, w_d_im;

            // Select the stage input: fresh operands or the stage before
            if (k == 0) begin : g_first
                assign w_v      = i_valid;
                assign w_side   = i_side;
                assign w_den    = i_den;
                assign w_rem_re = 63'(i_num_re[63:33]);
                assign w_rem_im = 63'(i_num_im[63:33]);
                assign w_sh_re  = QB'(i_num_re[32:0]) << FRAC_BITS;
                assign w_sh_im  = QB'(i_num_im[32:0]) << FRAC_BITS;
            end else begin : g_next
                assign w_v      = r_v[k-1];
                assign w_side   = r_side[k-1];
                assign w_den    = r_den[k-1];
                assign w_rem_re = r_rem_re[k-1];
                assign w_rem_im = r_rem_im[k-1];
                assign w_sh_re  = r_sh_re[k-1];
                assign w_sh_im  = r_sh_im[k-1];
            end

            // Shift in the next numerator bit, subtract the divisor if it fits
            assign w_t_re  = {w_rem_re, w_sh_re[QB-1]};
            assign w_t_im  = {w_rem_im, w_sh_im[QB-1]};
            assign w_ge_re = (w_t_re >= w_den);
            assign w_ge_im = (w_t_im >= w_den);
            assign w_d_re  = w_ge_re ? w_t_re - w_den : w_t_re;
            assign w_d_im  = w_ge_im ? w_t_im - w_den : w_t_im;

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[k] <= 1'b0;
                end else if (i_en) begin
                    r_v[k] <= w_v;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_side[k]   <= w_side;
                    r_den[k]    <= w_den;
                    r_rem_re[k] <= w_d_re[62:0];
                    r_rem_im[k] <= w_d_im[62:0];
                    r_sh_re[k]  <= {w_sh_re[QB-2:0], w_ge_re};
                    r_sh_im[k]  <= {w_sh_im[QB-2:0], w_ge_im};
                end
            end
        end
    endgenerate

    assign o_valid = r_v[QB-1];
    assign o_side  = r_side[QB-1];
    assign o_q_re  = r_sh_re[QB-1];
    assign o_q_im  = r_sh_im[QB-1];

endmodule

/* hw/rtl/cfpa_back.sv */
// Back pipeline: signed quotients, remainder products, result select, saturation.
// Depends on cfpa_pkg.
`timescale 1ns / 1ps

module cfpa_back import cfpa_pkg::*; #(
    parameter int EFF_W     = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  t_side                 i_side,
    input  logic [FRAC_BITS+32:0] i_q_re,
    input  logic [FRAC_BITS+32:0] i_q_im,
    output logic                  o_valid,
    output t_out                  o_res
);

    localparam int QB  = FRAC_BITS + 33;
    localparam int IRW = QB - FRAC_BITS + 1;
    localparam logic signed [RW-1:0] MAXV = (RW'(1) <<< (EFF_W - 1)) - RW'(1);
    localparam logic signed [RW-1:0] MINV = -(RW'(1) <<< (EFF_W - 1));

    function automatic logic signed [RW-1:0] clamp(input logic signed [RW-1:0] v);
        logic signed [RW-1:0] r;
        if (v > MAXV) begin
            r = MAXV;
        end else if (v < MINV) begin
            r = MINV;
        end else begin
            r = v;
        end
        return r;
    endfunction

    // Stage 1: apply signs to quotient and its integer part
    logic signed [QB:0]    w_qs_re, w_qs_im;
    logic signed [IRW-1:0] w_ir_re, w_ir_im;

    assign w_qs_re = i_side.nr_neg ? -$signed({1'b0, i_q_re}) : $signed({1'b0, i_q_re});
    assign w_qs_im = i_side.ni_neg ? -$signed({1'b0, i_q_im}) : $signed({1'b0, i_q_im});
    assign w_ir_re = i_side.nr_neg ? -$signed({1'b0, i_q_re[QB-1:FRAC_BITS]})
                                   :  $signed({1'b0, i_q_re[QB-1:FRAC_BITS]});
    assign w_ir_im = i_side.ni_neg ? -$signed({1'b0, i_q_im[QB-1:FRAC_BITS]})
                                   :  $signed({1'b0, i_q_im[QB-1:FRAC_BITS]});

    logic                  r1_v;
    t_side                 r1_side;
    logic signed [QB:0]    r1_qs_re, r1_qs_im;
    logic signed [IRW-1:0] r1_ir_re, r1_ir_im;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (i_en) begin
            r1_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_side  <= i_side;
            r1_qs_re <= w_qs_re;
            r1_qs_im <= w_qs_im;
            r1_ir_re <= w_ir_re;
            r1_ir_im <= w_ir_im;
        end
    end

    // Stage 2: integer quotient times divisor
    logic                      r2_v;
    t_side                     r2_side;
    logic signed [QB:0]        r2_qs_re, r2_qs_im;
    logic signed [QB:0]        r2_tq_re, r2_tq_im;
    logic signed [IRW+31:0]    r2_p_rr, r2_p_ii, r2_p_ri, r2_p_ir;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (i_en) begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_side  <= r1_side;
            r2_qs_re <= r1_qs_re;
            r2_qs_im <= r1_qs_im;
            r2_tq_re <= (QB+1)'(r1_ir_re) <<< FRAC_BITS;
            r2_tq_im <= (QB+1)'(r1_ir_im) <<< FRAC_BITS;
            r2_p_rr  <= r1_ir_re * r1_side.b_re;
            r2_p_ii  <= r1_ir_im * r1_side.b_im;
            r2_p_ri  <= r1_ir_re * r1_side.b_im;
            r2_p_ir  <= r1_ir_im * r1_side.b_re;
        end
    end

    // Stage 3: remainder and result select by operation
    logic signed [RW-1:0] w_rem_re, w_rem_im;
    logic signed [RW-1:0] w_sel_re, w_sel_im;
    logic                 w_dz;

    assign w_rem_re = RW'(r2_side.a_re) - RW'(r2_p_rr) + RW'(r2_p_ii);
    assign w_rem_im = RW'(r2_side.a_im) - RW'(r2_p_ri) - RW'(r2_p_ir);

    always_comb begin
        w_dz = 1'b0;
        case (r2_side.mode)
            MODE_ADD, MODE_SUB, MODE_MUL: begin
                w_sel_re = RW'(r2_side.drt_re);
                w_sel_im = RW'(r2_side.drt_im);
            end
            MODE_DIV: begin
                w_sel_re = RW'(r2_qs_re);
                w_sel_im = RW'(r2_qs_im);
                w_dz     = r2_side.dz;
            end
            MODE_QUO: begin
                w_sel_re = RW'(r2_tq_re);
                w_sel_im = RW'(r2_tq_im);
                w_dz     = r2_side.dz;
            end
            MODE_REM: begin
                w_sel_re = w_rem_re;
                w_sel_im = w_rem_im;
                w_dz     = r2_side.dz;
            end
            default: begin
                w_sel_re = '0;
                w_sel_im = '0;
            end
        endcase
    end

    logic                 r3_v;
    logic signed [RW-1:0] r3_re, r3_im;
    logic                 r3_dz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (i_en) begin
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_re <= w_dz ? RW'(0) : w_sel_re;
            r3_im <= w_dz ? RW'(0) : w_sel_im;
            r3_dz <= w_dz;
        end
    end

    // Saturate to EFF_W bits and form the status
    logic signed [RW-1:0] w_c_re, w_c_im;
    logic                 w_ovf;

    assign w_c_re = clamp(r3_re);
    assign w_c_im = clamp(r3_im);
    assign w_ovf  = (w_c_re != r3_re) || (w_c_im != r3_im);

    assign o_valid       = r3_v;
    assign o_res.res_re  = w_c_re[31:0];
    assign o_res.res_im  = w_c_im[31:0];
    assign o_res.status  = r3_dz ? ST_DZ : (w_ovf ? ST_OVF : ST_OK);

endmodule

/* hw/rtl/complex_fixed_point_alu_core.sv */
// Complex fixed-point ALU: add, subtract, multiply, divide, truncated quotient, remainder.
// Operands a and b arrive on i_in_* as one transfer; one result leaves on o_out_*.
// Both channels use valid/ready; a transfer happens when both are high at a clock edge.
// One item per cycle may enter while o_in_ready is high, and leave while i_out_ready is.
// From input transfer to o_out_valid every result passes four front stages, FRAC_BITS + 33
// divider stages (one quotient bit each), three back stages and the two-entry output buffer.
// Every operation takes the same path.
// Results saturate to DATA_WIDTH bits (at most 32) with status 1; a zero divisor in
// divide modes gives zero parts and status 2; unused modes give zeros and status 0.
// When the receiver stalls, results collect in the output buffer; the pipeline freezes
// once it is full and o_in_ready falls, so nothing is lost or repeated.
// Synchronous active-low reset empties the pipeline and the buffer.
// Depends on cfpa_pkg, cfpa_front, cfpa_div and cfpa_back.
`timescale 1ns / 1ps

module complex_fixed_point_alu_core import cfpa_pkg::*; #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    localparam int EFF_W = (DATA_WIDTH > DW) ? DW : ((DATA_WIDTH < 2) ? 2 : DATA_WIDTH);
    localparam int QB    = FRAC_BITS + 33;

    logic          w_en;
    logic          w_f_valid;
    t_side         w_f_side;
    logic [63:0]   w_num_re, w_num_im, w_den;
    logic          w_d_valid;
    t_side         w_d_side;
    logic [QB-1:0] w_q_re, w_q_im;
    logic          w_b_valid;
    t_out          w_res;

    // Output buffer state
    t_out       r_fifo [2];
    logic       r_wr_ptr, r_rd_ptr;
    logic [1:0] r_count;
    logic       w_push, w_pop;

    // Advance the pipeline whenever the buffer has room
    assign w_en       = (r_count != 2'd2);
    assign o_in_ready = w_en;

    cfpa_front #(
        .EFF_W     (EFF_W),
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (i_in_valid),
        .i_data   (i_in_data),
        .o_valid  (w_f_valid),
        .o_side   (w_f_side),
        .o_num_re (w_num_re),
        .o_num_im (w_num_im),
        .o_den    (w_den)
    );

    cfpa_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (w_f_valid),
        .i_side   (w_f_side),
        .i_num_re (w_num_re),
        .i_num_im (w_num_im),
        .i_den    (w_den),
        .o_valid  (w_d_valid),
        .o_side   (w_d_side),
        .o_q_re   (w_q_re),
        .o_q_im   (w_q_im)
    );

    cfpa_back #(
        .EFF_W     (EFF_W),
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_d_valid),
        .i_side  (w_d_side),
        .i_q_re  (w_q_re),
        .i_q_im  (w_q_im),
        .o_valid (w_b_valid),
        .o_res   (w_res)
    );

    // Buffer control: push finished results, pop on output transfer
    assign w_push = w_en && w_b_valid;
    assign w_pop  = (r_count != 2'd0) && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= 2'd0;
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
        end else begin
            r_count <= r_count + 2'(w_push) - 2'(w_pop);
            if (w_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_fifo[r_wr_ptr] <= w_res;
        end
    end

    assign o_out_valid = (r_count != 2'd0);
    assign o_out_data  = r_fifo[r_rd_ptr];

endmodule

/* hw/rtl/cfpa_checker.sv */
// Port-level checks of the complex fixed-point ALU core, bound to the top level.
// Depends on cfpa_pkg and complex_fixed_point_alu_core_assert.svh.
`timescale 1ns / 1ps
`include "complex_fixed_point_alu_core_assert.svh"

module cfpa_checker import cfpa_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_ready,
    input t_in  i_in_data,
    input logic o_out_valid,
    input logic i_out_ready,
    input t_out o_out_data
);

    logic w_in_xfer;

    assign w_in_xfer = i_in_valid && o_in_ready && (i_in_data.mode != MODE_ADD || 1'b1);

    // Status is one of the three defined codes
    `CFPA_ASSERT_IMP(a_status_code, i_clk, i_rst_n, o_out_valid, o_out_data.status == ST_OK || o_out_data.status == ST_OVF || o_out_data.status == ST_DZ)

    // Zero divisor always yields zero parts
    `CFPA_ASSERT_IMP(a_dz_zero, i_clk, i_rst_n, o_out_valid && o_out_data.status == ST_DZ, o_out_data.res_re == 32'sd0 && o_out_data.res_im == 32'sd0)

    // A stalled result holds
    `CFPA_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_data))

    // Reset empties the output and opens the input
    `CFPA_ASSERT_ALW(a_rst_empty, i_clk, !i_rst_n, !o_out_valid && o_in_ready)

    // A taken input with a free output side never blocks the next cycle
    `CFPA_ASSERT_NXT(a_ready_free, i_clk, i_rst_n, w_in_xfer && !o_out_valid, o_in_ready)

endmodule

bind complex_fixed_point_alu_core cfpa_checker u_cfpa_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
